// ----- src/angle_kalman_filter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Angle Kalman filter assertion macros
// Shared property shorthands for the filter core checks.
// ----------------------------------------------------------------------------
`ifndef ANGLE_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_KALMAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define AKF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define AKF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/akf_pkg.sv -----
// ----------------------------------------------------------------------------
// Angle Kalman filter package
// Payload types, unit handshake structs and fixed constants.
// ----------------------------------------------------------------------------
package akf_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [30:0] ANGLE_NOISE_RST   = 31'd16777;
  localparam logic [30:0] BIAS_NOISE_RST    = 31'd50332;
  localparam logic [30:0] MEASURE_NOISE_RST = 31'd503316;

  // Serial unit lengths: one multiplier bit or one quotient bit per cycle
  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 56;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic        [15:0] time_step;
  } akf_in_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] unbiased_rate;
    logic signed [31:0] bias_estimate;
  } akf_out_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- src/akf_ser_mul.sv -----
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add signed multiply, one multiplier bit per cycle on magnitudes.
// ----------------------------------------------------------------------------
module akf_ser_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  akf_pkg::mul_req_t   req,
  output akf_pkg::unit_sts_t  sts,
  output logic signed [63:0]  product
);
  import akf_pkg::*;

  localparam logic [5:0] LAST = 6'(MUL_STEPS - 1);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] ma_r, ma_nxt;
  logic [32:0] mb_r, mb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [32:0] mag_a, mag_b;
  logic [63:0] acc_add;

  assign mag_a   = req.op_a[32] ? (~req.op_a + 33'd1) : req.op_a;
  assign mag_b   = req.op_b[32] ? (~req.op_b + 33'd1) : req.op_b;
  assign acc_add = mb_r[0] ? (acc_r + ma_r) : acc_r;

  // Load on start, add one partial product per cycle, sign-fix at the end
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = req.op_a[32] ^ req.op_b[32];
      ma_nxt   = {31'd0, mag_a};
      mb_nxt   = mag_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_add;
      ma_nxt  = {ma_r[62:0], 1'b0};
      mb_nxt  = {1'b0, mb_r[32:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        prod_nxt = neg_r ? -$signed(acc_add) : $signed(acc_add);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = prod_r;

endmodule

// ----- src/akf_ser_div.sv -----
// ----------------------------------------------------------------------------
// Serial gain divider
// Restoring divide of num * 2^24 by den, one quotient bit per cycle,
// truncated toward zero; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module akf_ser_div (
  input  logic                clk,
  input  logic                rst_n,
  input  akf_pkg::div_req_t   req,
  output akf_pkg::unit_sts_t  sts,
  output logic signed [63:0]  quotient
);
  import akf_pkg::*;

  localparam logic [5:0] LAST = 6'(DIV_STEPS - 1);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [55:0] dvd_r, dvd_nxt;
  logic [33:0] dmag_r, dmag_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic signed [63:0] quo_r, quo_nxt;
  logic [31:0] mag_num;
  logic [33:0] mag_den;
  logic [34:0] trial;
  logic        fits;
  logic [55:0] dvd_shift;

  assign mag_num   = req.num[31] ? (~req.num + 32'd1) : req.num;
  assign mag_den   = req.den[33] ? (~req.den + 34'd1) : req.den;
  assign trial     = {rem_r, dvd_r[55]};
  assign fits      = trial >= {1'b0, dmag_r};
  assign dvd_shift = {dvd_r[54:0], fits};

  // Shift one dividend bit into the remainder and one quotient bit out
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    dvd_nxt  = dvd_r;
    dmag_nxt = dmag_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = req.num[31] ^ req.den[33];
      zero_nxt = (req.den == '0);
      dvd_nxt  = {mag_num, 24'd0};
      dmag_nxt = mag_den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? 34'(trial - {1'b0, dmag_r}) : trial[33:0];
      dvd_nxt = dvd_shift;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (zero_r) quo_nxt = '0;
        else if (neg_r) quo_nxt = -$signed({8'd0, dvd_shift});
        else quo_nxt = $signed({8'd0, dvd_shift});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    dvd_r  <= dvd_nxt;
    dmag_r <= dmag_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/angle_kalman_filter_core.sv -----
// ----------------------------------------------------------------------------
// Angle Kalman filter core
// Two-state angle/gyro-bias Kalman filter; a sequencer drives one serial
// multiplier and one serial divider through predict, gain and correct.
//
//   Channel  Ports                          Moves
//   in       in_valid/in_ready/in_data      angle, gyro rate, time step
//   out      out_valid/out_ready/out_data   filtered angle, rate, bias
//   cfg      cfg_valid/cfg_ready/cfg_*      noise register writes
//
// One item runs from transfer to result through the bit-serial multiplier
// (10 products) and the bit-serial divider (two gains), with single-cycle
// sequencer steps between them.
// Reset (rst_n low, synchronous) clears the state and loads the noise defaults.
// A result waits in the output register; the next item is taken meanwhile,
// and only the final load stalls while that register is still full.
// ----------------------------------------------------------------------------
module angle_kalman_filter_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  akf_pkg::akf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output akf_pkg::akf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import akf_pkg::*;
  `include "angle_kalman_filter_core_defines.svh"

  localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RATE   = 5'd1;
  localparam logic [4:0] ST_M_ANG  = 5'd2;
  localparam logic [4:0] ST_M_STEP = 5'd3;
  localparam logic [4:0] ST_INNER  = 5'd4;
  localparam logic [4:0] ST_M_PAA  = 5'd5;
  localparam logic [4:0] ST_M_PBB  = 5'd6;
  localparam logic [4:0] ST_DIV0   = 5'd7;
  localparam logic [4:0] ST_D_K0   = 5'd8;
  localparam logic [4:0] ST_D_K1   = 5'd9;
  localparam logic [4:0] ST_MUL_Y  = 5'd10;
  localparam logic [4:0] ST_M_ANG2 = 5'd11;
  localparam logic [4:0] ST_M_BIAS = 5'd12;
  localparam logic [4:0] ST_M_CBA  = 5'd13;
  localparam logic [4:0] ST_M_CBB  = 5'd14;
  localparam logic [4:0] ST_M_CAB  = 5'd15;
  localparam logic [4:0] ST_M_CAA  = 5'd16;
  localparam logic [4:0] ST_OUT    = 5'd17;

  function automatic logic signed [31:0] sat(input logic signed [63:0] x);
    if (x > SAT_HI) return SAT_HI[31:0];
    if (x < SAT_LO) return SAT_LO[31:0];
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
    return (x + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [63:0] sx(input logic signed [31:0] v);
    return 64'(v);
  endfunction

  logic [4:0]  st_r, st_nxt;
  logic [30:0] apn_r, bpn_r, mn_r;
  logic signed [31:0] meas_r, gyro_r;
  logic [15:0] dt_r;
  logic signed [31:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [31:0] caa_r, caa_nxt, cab_r, cab_nxt;
  logic signed [31:0] cba_r, cba_nxt, cbb_r, cbb_nxt;
  logic signed [31:0] rate_r, rate_nxt, step_r, step_nxt;
  logic signed [31:0] k0_r, k0_nxt, k1_r, k1_nxt, y_r, y_nxt;
  logic        out_valid_r, out_valid_nxt;
  akf_out_t    out_data_r, out_data_nxt;

  mul_req_t    mreq;
  div_req_t    dreq;
  unit_sts_t   msts, dsts;
  logic signed [63:0] prod, quo;
  logic signed [31:0] rate_c, inner_c;
  logic signed [32:0] dt_op;
  logic signed [63:0] s_c;

  akf_ser_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .sts(msts), .product(prod));
  akf_ser_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .sts(dsts), .quotient(quo));

  assign dt_op   = $signed({17'd0, dt_r});
  assign rate_c  = sat(sx(gyro_r) - sx(bias_r));
  assign inner_c = sat(sx(step_r) - sx(cab_r) - sx(cba_r) + $signed({33'd0, apn_r}));
  assign s_c     = sx(caa_r) + $signed({33'd0, mn_r});

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Sequence the predict, gain and correct steps over the serial units
  always_comb begin
    st_nxt        = st_r;
    ang_nxt       = ang_r;
    bias_nxt      = bias_r;
    caa_nxt       = caa_r;
    cab_nxt       = cab_r;
    cba_nxt       = cba_r;
    cbb_nxt       = cbb_r;
    rate_nxt      = rate_r;
    step_nxt      = step_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mreq          = '0;
    dreq          = '0;
    dreq.num      = caa_r;
    dreq.den      = s_c[33:0];
    case (st_r)
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_RATE;
      end
      ST_RATE: begin
        rate_nxt = rate_c;
        mreq     = '{1'b1, dt_op, 33'(rate_c)};
        st_nxt   = ST_M_ANG;
      end
      ST_M_ANG: begin
        if (msts.done) begin
          ang_nxt = sat(sx(ang_r) + rnd16(prod));
          mreq    = '{1'b1, dt_op, 33'(cbb_r)};
          st_nxt  = ST_M_STEP;
        end
      end
      ST_M_STEP: begin
        if (msts.done) begin
          step_nxt = sat(rnd16(prod));
          st_nxt   = ST_INNER;
        end
      end
      ST_INNER: begin
        cab_nxt = sat(sx(cab_r) - sx(step_r));
        cba_nxt = sat(sx(cba_r) - sx(step_r));
        mreq    = '{1'b1, dt_op, 33'(inner_c)};
        st_nxt  = ST_M_PAA;
      end
      ST_M_PAA: begin
        if (msts.done) begin
          caa_nxt = sat(sx(caa_r) + rnd16(prod));
          mreq    = '{1'b1, $signed({2'd0, bpn_r}), dt_op};
          st_nxt  = ST_M_PBB;
        end
      end
      ST_M_PBB: begin
        if (msts.done) begin
          cbb_nxt = sat(sx(cbb_r) + rnd16(prod));
          st_nxt  = ST_DIV0;
        end
      end
      ST_DIV0: begin
        dreq.start = 1'b1;
        st_nxt     = ST_D_K0;
      end
      ST_D_K0: begin
        if (dsts.done) begin
          k0_nxt     = sat(quo);
          dreq.start = 1'b1;
          dreq.num   = cba_r;
          st_nxt     = ST_D_K1;
        end
      end
      ST_D_K1: begin
        if (dsts.done) begin
          k1_nxt = sat(quo);
          y_nxt  = sat(sx(meas_r) - sx(ang_r));
          st_nxt = ST_MUL_Y;
        end
      end
      ST_MUL_Y: begin
        mreq   = '{1'b1, 33'(k0_r), 33'(y_r)};
        st_nxt = ST_M_ANG2;
      end
      ST_M_ANG2: begin
        if (msts.done) begin
          ang_nxt = sat(sx(ang_r) + rnd24(prod));
          mreq    = '{1'b1, 33'(k1_r), 33'(y_r)};
          st_nxt  = ST_M_BIAS;
        end
      end
      ST_M_BIAS: begin
        if (msts.done) begin
          bias_nxt = sat(sx(bias_r) + rnd24(prod));
          mreq     = '{1'b1, 33'(k1_r), 33'(caa_r)};
          st_nxt   = ST_M_CBA;
        end
      end
      ST_M_CBA: begin
        if (msts.done) begin
          cba_nxt = sat(sx(cba_r) - rnd24(prod));
          mreq    = '{1'b1, 33'(k1_r), 33'(cab_r)};
          st_nxt  = ST_M_CBB;
        end
      end
      ST_M_CBB: begin
        if (msts.done) begin
          cbb_nxt = sat(sx(cbb_r) - rnd24(prod));
          mreq    = '{1'b1, 33'(k0_r), 33'(cab_r)};
          st_nxt  = ST_M_CAB;
        end
      end
      ST_M_CAB: begin
        if (msts.done) begin
          cab_nxt = sat(sx(cab_r) - rnd24(prod));
          mreq    = '{1'b1, 33'(k0_r), 33'(caa_r)};
          st_nxt  = ST_M_CAA;
        end
      end
      ST_M_CAA: begin
        if (msts.done) begin
          caa_nxt = sat(sx(caa_r) - rnd24(prod));
          st_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.filtered_angle = ang_r;
          out_data_nxt.unbiased_rate  = rate_r;
          out_data_nxt.bias_estimate  = bias_r;
          st_nxt                      = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      apn_r       <= ANGLE_NOISE_RST;
      bpn_r       <= BIAS_NOISE_RST;
      mn_r        <= MEASURE_NOISE_RST;
      ang_r       <= '0;
      bias_r      <= '0;
      caa_r       <= '0;
      cab_r       <= '0;
      cba_r       <= '0;
      cbb_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r       <= ang_nxt;
      bias_r      <= bias_nxt;
      caa_r       <= caa_nxt;
      cab_r       <= cab_nxt;
      cba_r       <= cba_nxt;
      cbb_r       <= cbb_nxt;
      // Apply a configuration transfer
      if (cfg_valid) begin
        case (cfg_index)
          REG_ANGLE_NOISE:   apn_r <= cfg_data[30:0];
          REG_BIAS_NOISE:    bpn_r <= cfg_data[30:0];
          REG_MEASURE_NOISE: mn_r  <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
    // Capture the input transfer
    if (in_valid && in_ready) begin
      meas_r <= in_data.measured_angle;
      gyro_r <= in_data.gyro_rate;
      dt_r   <= in_data.time_step;
    end
    rate_r     <= rate_nxt;
    step_r     <= step_nxt;
    k0_r       <= k0_nxt;
    k1_r       <= k1_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AKF_ASSERT_NOW(a_units_exclusive, clk, rst_n, msts.busy, !dsts.busy, "mul and div both busy")
  `AKF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, st_r == ST_RATE, "accept did not start sequence")
  `AKF_ASSERT_NEXT(a_out_load, clk, rst_n, st_r == ST_OUT && !out_valid_r, out_valid_r && st_r == ST_IDLE, "result not loaded")

endmodule

// ----- tb/angle_kalman_filter_core_tb.sv -----
// ----------------------------------------------------------------------------
// Angle Kalman filter core testbench
// Drives angle, gyro rate and time step samples through the filter core and
// compares each filtered angle, unbiased rate and bias estimate against a
// fixed-point model of the predict/gain/correct update kept in this bench.
// ----------------------------------------------------------------------------
module angle_kalman_filter_core_tb;
  import akf_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 800;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  akf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  akf_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Model state: estimates Q15.16, covariance Q7.24
  longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
  logic [30:0] q_angle, q_bias, r_meas;

  akf_out_t pending_estimates[$];
  int  error_count;
  int  quiet_cycles;
  bit  calm_mode;
  int  hold_request;

  angle_kalman_filter_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Round to nearest, halves toward plus infinity
  function automatic longint round_shift(longint x, int n);
    longint half;
    half = 64'sd1 <<< (n - 1);
    return (x + half) >>> n;
  endfunction

  function automatic longint gain_q24(longint num, longint den);
    if (den == 0) return 0;
    return sat32((num <<< 24) / den);
  endfunction

  // Run one filter update on the model state and return the result
  function automatic akf_out_t kalman_update(akf_in_t s);
    longint meas, gyro, dt, rate, grow, inner, innov_var, k0, k1, resid, p00, p01;
    akf_out_t r;
    meas = longint'(s.measured_angle);
    gyro = longint'(s.gyro_rate);
    dt   = longint'({48'd0, s.time_step});
    // predict
    rate      = sat32(gyro - bias_est);
    angle_est = sat32(angle_est + round_shift(dt * rate, 16));
    grow  = sat32(round_shift(dt * p_bb, 16));
    inner = sat32(grow - p_ab - p_ba + longint'({33'd0, q_angle}));
    p_aa  = sat32(p_aa + round_shift(dt * inner, 16));
    p_ab  = sat32(p_ab - grow);
    p_ba  = sat32(p_ba - grow);
    p_bb  = sat32(p_bb + round_shift(longint'({33'd0, q_bias}) * dt, 16));
    // gain
    innov_var = p_aa + longint'({33'd0, r_meas});
    k0 = gain_q24(p_aa, innov_var);
    k1 = gain_q24(p_ba, innov_var);
    // correct
    resid     = sat32(meas - angle_est);
    angle_est = sat32(angle_est + round_shift(k0 * resid, 24));
    bias_est  = sat32(bias_est + round_shift(k1 * resid, 24));
    p00  = p_aa;
    p01  = p_ab;
    p_aa = sat32(p_aa - round_shift(k0 * p00, 24));
    p_ab = sat32(p_ab - round_shift(k0 * p01, 24));
    p_ba = sat32(p_ba - round_shift(k1 * p00, 24));
    p_bb = sat32(p_bb - round_shift(k1 * p01, 24));
    r.filtered_angle = angle_est[31:0];
    r.unbiased_rate  = rate[31:0];
    r.bias_estimate  = bias_est[31:0];
    return r;
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(akf_in_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    forever begin
      @(negedge clk);
      if (in_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_estimates.push_back(kalman_update(s));
  endtask

  // Drop valid for a random gap now and then
  task automatic sender_gap();
    if (!calm_mode && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(800, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one noise register with the core idle
  task automatic write_noise(logic [1:0] idx, logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ANGLE_NOISE:   q_angle = value[30:0];
      REG_BIAS_NOISE:    q_bias  = value[30:0];
      REG_MEASURE_NOISE: r_meas  = value[30:0];
      default: ;
    endcase
  endtask

  function automatic akf_in_t make_sample(logic [31:0] a, logic [31:0] g, logic [15:0] t);
    akf_in_t s;
    s.measured_angle = a;
    s.gyro_rate      = g;
    s.time_step      = t;
    return s;
  endfunction

  // Mostly plausible IMU data, some full-range noise
  function automatic akf_in_t random_sample();
    if ($urandom_range(99) < 70)
      return make_sample(32'($signed($urandom_range(180 << 16)) - (90 << 16)),
                         32'($signed($urandom_range(100 << 16)) - (50 << 16)),
                         16'($urandom_range(200, 20)));
    return make_sample($urandom, $urandom, 16'($urandom));
  endfunction

  task automatic run_random(int count);
    repeat (count) begin
      send_sample(random_sample());
      sender_gap();
    end
  endtask

  task automatic test_field_extremes();
    send_sample(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    send_sample(make_sample(32'h8000_0000, 32'h8000_0000, 16'hFFFF));
    send_sample(make_sample(32'h0000_0000, 32'h0000_0000, 16'h0000));
    send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001));
    send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
    send_sample(make_sample(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000));
    send_sample(make_sample(32'h0001_0000, 32'hFFFF_0000, 16'h0041));
  endtask

  // Zero noise everywhere from a cleared covariance: innovation variance is zero
  task automatic test_zero_innovation();
    write_noise(REG_ANGLE_NOISE, 32'h0000_0000);
    write_noise(REG_BIAS_NOISE, 32'h0000_0000);
    write_noise(REG_MEASURE_NOISE, 32'h8000_0000);
    send_sample(make_sample(32'h0010_0000, 32'h0002_0000, 16'h0041));
    send_sample(make_sample(32'hFFF0_0000, 32'hFFFE_0000, 16'hFFFF));
    send_sample(make_sample(32'h1234_5678, 32'h0000_0000, 16'h0000));
  endtask

  task automatic test_noise_extremes();
    write_noise(REG_ANGLE_NOISE, 32'hFFFF_FFFF);
    write_noise(REG_BIAS_NOISE, 32'h7FFF_FFFF);
    write_noise(REG_MEASURE_NOISE, 32'h7FFF_FFFF);
    test_field_extremes();
    run_random(60);
    write_noise(REG_ANGLE_NOISE, 32'h0000_0001);
    write_noise(REG_BIAS_NOISE, 32'h0000_0000);
    write_noise(REG_MEASURE_NOISE, 32'h0000_0001);
    run_random(60);
  endtask

  task automatic test_default_random();
    write_noise(REG_ANGLE_NOISE, {1'b0, ANGLE_NOISE_RST});
    write_noise(REG_BIAS_NOISE, {1'b0, BIAS_NOISE_RST});
    write_noise(REG_MEASURE_NOISE, {1'b0, MEASURE_NOISE_RST});
    run_random(150);
    calm_mode = 1'b1;
    run_random(60);
    calm_mode = 1'b0;
  endtask

  task automatic test_random_noise();
    repeat (3) begin
      write_noise(REG_ANGLE_NOISE, $urandom);
      write_noise(REG_BIAS_NOISE, $urandom);
      write_noise(REG_MEASURE_NOISE, $urandom | 32'h1);
      run_random(80);
    end
  endtask

  // Hold the receiver off while the sender keeps offering
  task automatic test_output_backpressure();
    hold_request = 4000;
    calm_mode = 1'b1;
    run_random(20);
    calm_mode = 1'b0;
  endtask

  // Receiver ready: random idling, long holds on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm_mode || ($urandom_range(99) >= 23);
      end
    end
  end

  // Check each result transfer; also watch for a stuck run
  always @(negedge clk) begin
    akf_out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result %h", out_data);
        end else begin
          want = pending_estimates.pop_front();
          if (out_data !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: angle %h/%h rate %h/%h bias %h/%h (exp/act)",
                       want.filtered_angle, out_data.filtered_angle,
                       want.unbiased_rate, out_data.unbiased_rate,
                       want.bias_estimate, out_data.bias_estimate);
          end
        end
      end
    end
  end

  initial begin
    error_count  = 0;
    quiet_cycles = 0;
    calm_mode    = 1'b0;
    hold_request = 0;
    angle_est = 0; bias_est = 0;
    p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
    q_angle = ANGLE_NOISE_RST;
    q_bias  = BIAS_NOISE_RST;
    r_meas  = MEASURE_NOISE_RST;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ANGLE_NOISE;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_innovation();
    test_noise_extremes();
    test_default_random();
    test_output_backpressure();
    test_random_noise();

    // Drain, then allow time for any stray result
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
